// File: src/av1obu_pkg.sv
// shared types and constants for the av1 obu packet scanner
package av1obu_pkg;

    localparam int unsigned REM_W = 56;
    localparam int unsigned LEB_IDX_W = 3;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_EXT     = 2'd1;
    localparam logic [1:0] PH_LEB     = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [3:0] KIND_SEQ_HDR   = 4'd1;
    localparam logic [3:0] KIND_FRAME_HDR = 4'd3;
    localparam logic [3:0] KIND_METADATA  = 4'd5;
    localparam logic [3:0] KIND_FRAME     = 4'd6;

    localparam logic [7:0] LEB_DATA_MASK = 8'h7f;
    localparam logic [7:0] LEB_CONT_BIT  = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_header;
        logic       last_out;
        logic       is_keyframe;
    } t_out;

endpackage

// File: src/av1obu_packet_scanner_core.sv
// top level of the av1 obu packet scanner: walker plus output skid stage
//
// channel   dir   handshake                   payload
// input     in    i_in_valid / o_in_ready     i_in_data  (t_in)
// output    out   o_out_valid / i_out_ready   o_out_data (t_out)
//
// one byte per cycle while o_in_ready is high; results are registered
// the walker state updates in the accept cycle, so bytes follow back to back
// the two-entry output stage holds one extra result during a stall
// before o_in_ready drops; o_in_ready comes straight from a register
// synchronous active-low reset returns to the expect-header state
module av1_obu_packet_scanner_core #(
    parameter int MAX_LEB_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  av1obu_pkg::t_in  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output av1obu_pkg::t_out o_out_data
);

    logic             accept;
    logic             take;
    av1obu_pkg::t_out result;

    logic             r_out_valid;
    logic             r_skid_valid;
    av1obu_pkg::t_out r_out;
    av1obu_pkg::t_out r_skid;

    assign o_in_ready  = !r_skid_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign take        = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    av1obu_walker #(
        .MAX_LEB_BYTES(MAX_LEB_BYTES)
    ) u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            if (r_out_valid) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

endmodule

// File: src/av1obu_walker.sv
// obu walk state and per-byte result logic
module av1obu_walker #(
    parameter int MAX_LEB_BYTES = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  av1obu_pkg::t_in i_data,
    output av1obu_pkg::t_out o_result
);

    logic [1:0]                          r_phase, n_phase;
    logic [3:0]                          r_obu_kind, n_obu_kind;
    logic                                r_ext_pending, n_ext_pending;
    logic                                r_has_length, n_has_length;
    logic [av1obu_pkg::LEB_IDX_W-1:0]    r_leb_index, n_leb_index;
    logic [av1obu_pkg::REM_W-1:0]        r_remaining, n_remaining;
    logic                                r_header_obu, n_header_obu;
    logic                                r_decided, n_decided;
    logic                                r_key_result, n_key_result;

    logic [7:0]                          b;
    logic                                flag;
    logic [3:0]                          hdr_kind;
    logic                                hdr_is_header;
    logic [5:0]                          leb_shift;
    logic [av1obu_pkg::REM_W-1:0]        leb_acc;
    logic [3:0]                          leb_count;
    logic [av1obu_pkg::REM_W-1:0]        rem_dec;

    always_comb begin
        b             = i_data.in_byte;
        hdr_kind      = b[6:3];
        hdr_is_header = (hdr_kind == av1obu_pkg::KIND_SEQ_HDR) ||
                        (hdr_kind == av1obu_pkg::KIND_METADATA);
        leb_shift     = 6'(r_leb_index) * 6'd7;
        leb_acc       = r_remaining |
                        (av1obu_pkg::REM_W'(b & av1obu_pkg::LEB_DATA_MASK) << leb_shift);
        leb_count     = {1'b0, r_leb_index} + 4'd1;
        rem_dec       = (r_remaining != '0) ? r_remaining - 1'b1 : r_remaining;

        n_phase       = r_phase;
        n_obu_kind    = r_obu_kind;
        n_ext_pending = r_ext_pending;
        n_has_length  = r_has_length;
        n_leb_index   = r_leb_index;
        n_remaining   = r_remaining;
        n_header_obu  = r_header_obu;
        n_decided     = r_decided;
        n_key_result  = r_key_result;
        flag          = r_header_obu;

        unique case (r_phase)
            av1obu_pkg::PH_HEADER: begin
                n_obu_kind    = hdr_kind;
                n_ext_pending = b[2];
                n_has_length  = b[1];
                n_header_obu  = hdr_is_header;
                flag          = hdr_is_header;
                if (b[2]) begin
                    n_phase = av1obu_pkg::PH_EXT;
                end else if (b[1]) begin
                    n_phase     = av1obu_pkg::PH_LEB;
                    n_leb_index = '0;
                    n_remaining = '0;
                end else begin
                    n_phase = av1obu_pkg::PH_PAYLOAD;
                end
            end
            av1obu_pkg::PH_EXT: begin
                n_ext_pending = 1'b0;
                if (r_has_length) begin
                    n_phase     = av1obu_pkg::PH_LEB;
                    n_leb_index = '0;
                    n_remaining = '0;
                end else begin
                    n_phase = av1obu_pkg::PH_PAYLOAD;
                end
            end
            av1obu_pkg::PH_LEB: begin
                n_remaining = leb_acc;
                if ((b & av1obu_pkg::LEB_CONT_BIT) == 8'd0 ||
                    leb_count >= 4'(MAX_LEB_BYTES)) begin
                    n_leb_index = '0;
                    n_phase     = (leb_acc == '0) ? av1obu_pkg::PH_HEADER
                                                  : av1obu_pkg::PH_PAYLOAD;
                end else begin
                    n_leb_index = r_leb_index + 1'b1;
                end
            end
            av1obu_pkg::PH_PAYLOAD: begin
                if ((r_obu_kind == av1obu_pkg::KIND_FRAME ||
                     r_obu_kind == av1obu_pkg::KIND_FRAME_HDR) && !r_decided) begin
                    n_decided    = 1'b1;
                    n_key_result = !b[7] && (b[6:5] == 2'd0);
                end
                if (r_has_length) begin
                    n_remaining = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = av1obu_pkg::PH_HEADER;
                    end
                end
            end
            default: begin
                n_phase = av1obu_pkg::PH_HEADER;
            end
        endcase

        o_result.out_byte    = b;
        o_result.to_header   = flag;
        o_result.last_out    = i_data.last_in;
        o_result.is_keyframe = i_data.last_in & n_decided & n_key_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_data.last_in)) begin
            r_phase       <= av1obu_pkg::PH_HEADER;
            r_obu_kind    <= '0;
            r_ext_pending <= 1'b0;
            r_has_length  <= 1'b0;
            r_leb_index   <= '0;
            r_remaining   <= '0;
            r_header_obu  <= 1'b0;
            r_decided     <= 1'b0;
            r_key_result  <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_obu_kind    <= n_obu_kind;
            r_ext_pending <= n_ext_pending;
            r_has_length  <= n_has_length;
            r_leb_index   <= n_leb_index;
            r_remaining   <= n_remaining;
            r_header_obu  <= n_header_obu;
            r_decided     <= n_decided;
            r_key_result  <= n_key_result;
        end
    end

endmodule
